// ===== design/fbs_pkg.sv =====
// Package for the frame brightness statistics block.
// Holds shared widths, the per-frame record types and the constant-division helpers.
// No dependencies; every other file of the block uses it.
package fbs_pkg;

    localparam int unsigned FRAME_WORDS_DEF  = 16;
    localparam int unsigned ZONE_SAMPLES_DEF = 16;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned WORD_BYTES = 4;
    localparam int unsigned ZONES     = 4;
    localparam logic [1:0]  LAST_ZONE = 2'd3;

    // The sample sums must hold 255 times the largest sample count (4 * 4096 samples).
    localparam int unsigned SUM_W  = 22;
    // Reciprocal multipliers for exact division of a SUM_W-bit value by a constant.
    localparam int unsigned MULT_W = 24;
    localparam int unsigned PROD_W = SUM_W + MULT_W;

    // x * 100 / 255 for x below 256, done as a multiply by ceil(2^23 / 255) * 100.
    localparam int unsigned PCT_PROD_W = 30;
    localparam logic [PCT_PROD_W-1:0] PCT_MULT = 30'd3289700;
    localparam int unsigned PCT_SHIFT  = 23;

    localparam int unsigned PCT_W      = 7;
    localparam int unsigned NONZERO_W  = 5;
    localparam int unsigned CHANGE_W   = 4;
    localparam int unsigned SAMPLES_W  = 7;

    typedef logic [SUM_W-1:0]  t_sum;
    typedef logic [BYTE_W-1:0] t_byte;

    // Running totals of one finished frame.
    typedef struct packed {
        logic [WORD_W-1:0]    first_word;
        logic [WORD_W-1:0]    second_word;
        logic [WORD_W-1:0]    final_word;
        logic [NONZERO_W-1:0] nonzero_words;
        logic [CHANGE_W-1:0]  changing_words;
        logic [WORD_W-1:0]    word_sum;
        t_sum                 sample_acc;
        t_byte                lowest_sample;
        t_byte                highest_sample;
        t_sum [ZONES-1:0]     zone_acc;
    } t_frame_totals;

    // Frame record after the divisions by the sample counts.
    typedef struct packed {
        logic [WORD_W-1:0]    first_word;
        logic [WORD_W-1:0]    second_word;
        logic [WORD_W-1:0]    final_word;
        logic [NONZERO_W-1:0] nonzero_words;
        logic [CHANGE_W-1:0]  changing_words;
        logic [WORD_W-1:0]    word_sum;
        t_byte                average_sample;
        t_byte                lowest_sample;
        t_byte                highest_sample;
        t_byte [ZONES-1:0]    zone_mean;
    } t_frame_means;

    typedef struct packed {
        logic [WORD_W-1:0]      first_word;
        logic [WORD_W-1:0]      second_word;
        logic [WORD_W-1:0]      final_word;
        logic [NONZERO_W-1:0]   nonzero_words;
        logic [CHANGE_W-1:0]    changing_words;
        logic [WORD_W-1:0]      word_sum;
        logic [SAMPLES_W-1:0]   samples_seen;
        t_byte                  average_sample;
        t_byte                  lowest_sample;
        t_byte                  highest_sample;
        logic [PCT_W-1:0]       brightness_percent;
        logic [ZONES*PCT_W-1:0] zone_percents;
    } t_result;

    // Number of samples that zone k receives in one frame.
    function automatic int unsigned zone_samples_of(input int unsigned k, input int unsigned fw,
                                                    input int unsigned zs);
        int unsigned total;
        int unsigned start;
        int unsigned left;
        total = WORD_BYTES * fw;
        start = k * zs;
        if (start >= total) begin
            return 0;
        end
        left = total - start;
        if (k == ZONES - 1 || left < zs) begin
            return left;
        end
        return zs;
    endfunction

    function automatic logic [PCT_W-1:0] pct_of(input t_byte value);
        logic [PCT_PROD_W-1:0] prod;
        prod = PCT_PROD_W'(value) * PCT_MULT;
        return PCT_W'(prod >> PCT_SHIFT);
    endfunction

endpackage

// ===== design/fbs_if.sv =====
// Stream channels of the frame brightness statistics block.
// Depends on fbs_pkg for the field widths.
interface fbs_in_if;
    logic                          valid;
    logic                          ready;
    logic [fbs_pkg::WORD_W-1:0]    capture_word;

    modport source (output valid, capture_word, input ready);
    modport sink   (input valid, capture_word, output ready);
endinterface

interface fbs_out_if;
    logic                                    valid;
    logic                                    ready;
    logic [fbs_pkg::WORD_W-1:0]              first_word;
    logic [fbs_pkg::WORD_W-1:0]              second_word;
    logic [fbs_pkg::WORD_W-1:0]              final_word;
    logic [fbs_pkg::NONZERO_W-1:0]           nonzero_words;
    logic [fbs_pkg::CHANGE_W-1:0]            changing_words;
    logic [fbs_pkg::WORD_W-1:0]              word_sum;
    logic [fbs_pkg::SAMPLES_W-1:0]           samples_seen;
    logic [fbs_pkg::BYTE_W-1:0]              average_sample;
    logic [fbs_pkg::BYTE_W-1:0]              lowest_sample;
    logic [fbs_pkg::BYTE_W-1:0]              highest_sample;
    logic [fbs_pkg::PCT_W-1:0]               brightness_percent;
    logic [fbs_pkg::ZONES*fbs_pkg::PCT_W-1:0] zone_percents;

    modport source (output valid, first_word, second_word, final_word, nonzero_words,
                    changing_words, word_sum, samples_seen, average_sample, lowest_sample,
                    highest_sample, brightness_percent, zone_percents, input ready);
    modport sink   (input valid, first_word, second_word, final_word, nonzero_words,
                    changing_words, word_sum, samples_seen, average_sample, lowest_sample,
                    highest_sample, brightness_percent, zone_percents, output ready);
endinterface

// ===== design/frame_brightness_statistics_core.sv =====
// Frame brightness statistics, top level.
// Input channel i_capture carries one 32-bit captured word per transfer, four 8-bit
// samples with the low byte first. Every FRAME_WORDS words form one frame; after the
// last word of a frame one result leaves on o_result, and no result is produced for the
// other words. The result holds the first, second and last words, the nonzero and
// changing word counts, the wrapping word sum, the sample count, the average, minimum
// and maximum sample, the brightness percent and four zone percents.
// Throughput is one word per clock cycle while no closing word waits. A result reaches
// o_result through three registers after the transfer of the frame's last word: the
// accumulator loads its totals register at that transfer, the reciprocal multipliers
// that divide by the sample counts feed the divide register, and the percent multipliers
// feed the output register. When o_result is stalled, results wait in the three stage
// registers; words that do not close a frame are still taken, and a closing word waits
// only when all three stages hold a result.
// Reset is synchronous and active low: it empties the pipeline and starts a new frame.
// Depends on fbs_pkg, fbs_if, fbs_accum, fbs_divide and fbs_percent.
module frame_brightness_statistics_core #(
    parameter int unsigned FRAME_WORDS  = fbs_pkg::FRAME_WORDS_DEF,
    parameter int unsigned ZONE_SAMPLES = fbs_pkg::ZONE_SAMPLES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fbs_in_if.sink    i_capture,
    fbs_out_if.source o_result
);

    logic                   w_tot_valid;
    logic                   w_tot_ready;
    fbs_pkg::t_frame_totals w_totals;
    logic                   w_mean_valid;
    logic                   w_mean_ready;
    fbs_pkg::t_frame_means  w_means;

    fbs_accum #(
        .FRAME_WORDS  (FRAME_WORDS),
        .ZONE_SAMPLES (ZONE_SAMPLES)
    ) u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_capture (i_capture),
        .i_ready   (w_tot_ready),
        .o_valid   (w_tot_valid),
        .o_totals  (w_totals)
    );

    fbs_divide #(
        .FRAME_WORDS  (FRAME_WORDS),
        .ZONE_SAMPLES (ZONE_SAMPLES)
    ) u_divide (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_tot_valid),
        .i_totals (w_totals),
        .o_ready  (w_tot_ready),
        .o_valid  (w_mean_valid),
        .o_means  (w_means),
        .i_ready  (w_mean_ready)
    );

    fbs_percent #(
        .FRAME_WORDS (FRAME_WORDS)
    ) u_percent (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_mean_valid),
        .i_means  (w_means),
        .o_ready  (w_mean_ready),
        .o_result (o_result)
    );

    // A frame's totals must not be dropped while the divide stage is full.
    a_totals_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tot_valid && !w_tot_ready) |=> w_tot_valid)
        else $error("frame totals lost while the divide stage was stalled");

    a_min_max_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.lowest_sample <= o_result.highest_sample))
        else $error("lowest sample above highest sample");

    a_average_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> ((o_result.average_sample >= o_result.lowest_sample)
                         && (o_result.average_sample <= o_result.highest_sample)))
        else $error("average sample outside the frame's sample range");

    a_percent_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.brightness_percent <= 7'd100))
        else $error("brightness percent above 100");

endmodule

// ===== design/fbs_accum.sv =====
// Per-word accumulation of the frame statistics and the frame totals register.
// Depends on fbs_pkg and the fbs_in_if channel.
module fbs_accum #(
    parameter int unsigned FRAME_WORDS  = fbs_pkg::FRAME_WORDS_DEF,
    parameter int unsigned ZONE_SAMPLES = fbs_pkg::ZONE_SAMPLES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    fbs_in_if.sink                 i_capture,
    input  logic                   i_ready,
    output logic                   o_valid,
    output fbs_pkg::t_frame_totals o_totals
);

    localparam int unsigned POS_W   = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
    localparam int unsigned ZFILL_W = (ZONE_SAMPLES > 1) ? $clog2(ZONE_SAMPLES) : 1;
    localparam logic [POS_W-1:0]   LAST_POS  = POS_W'(FRAME_WORDS - 1);
    localparam logic [ZFILL_W-1:0] LAST_FILL = ZFILL_W'(ZONE_SAMPLES - 1);
    localparam logic [POS_W-1:0]   FIRST_POS  = '0;
    localparam logic [POS_W-1:0]   SECOND_POS = POS_W'(1);

    logic [POS_W-1:0]                r_pos, n_pos;
    logic [fbs_pkg::WORD_W-1:0]      r_first, n_first;
    logic [fbs_pkg::WORD_W-1:0]      r_second, n_second;
    logic [fbs_pkg::WORD_W-1:0]      r_prev;
    logic [fbs_pkg::NONZERO_W-1:0]   r_nonzero, n_nonzero;
    logic [fbs_pkg::CHANGE_W-1:0]    r_change, n_change;
    logic [fbs_pkg::WORD_W-1:0]      r_wsum, n_wsum;
    fbs_pkg::t_sum                   r_ssum, n_ssum;
    fbs_pkg::t_byte                  r_min, n_min;
    fbs_pkg::t_byte                  r_max, n_max;
    fbs_pkg::t_sum                   r_zsum [fbs_pkg::ZONES];
    fbs_pkg::t_sum                   n_zsum [fbs_pkg::ZONES];
    logic [1:0]                      r_zone, n_zone;
    logic [ZFILL_W-1:0]              r_zfill, n_zfill;
    logic                            r_valid;
    fbs_pkg::t_frame_totals          r_totals, n_totals;

    logic [fbs_pkg::WORD_W-1:0]      w_word;
    logic                            w_last;
    logic                            w_accept;
    logic                            w_clear;
    fbs_pkg::t_byte                  w_smp;

    assign w_word   = i_capture.capture_word;
    assign w_last   = (r_pos == LAST_POS);
    // Only the closing word of a frame needs room in the totals register.
    assign i_capture.ready = !w_last || !r_valid || i_ready;
    assign w_accept = i_capture.valid && i_capture.ready;
    assign w_clear  = !i_rst_n || (w_accept && w_last);

    always_comb begin
        n_pos     = r_pos + POS_W'(1);
        n_first   = (r_pos == FIRST_POS) ? w_word : r_first;
        n_second  = (r_pos == SECOND_POS) ? w_word : r_second;
        n_nonzero = r_nonzero + fbs_pkg::NONZERO_W'(w_word != '0);
        n_change  = r_change
                  + fbs_pkg::CHANGE_W'((r_pos != FIRST_POS) && (w_word != r_prev));
        n_wsum    = r_wsum + w_word;
    end

    // Four samples a word; the zone pointer can step several times within one word
    // when zones are short.
    always_comb begin
        n_ssum  = r_ssum;
        n_min   = r_min;
        n_max   = r_max;
        n_zone  = r_zone;
        n_zfill = r_zfill;
        w_smp   = '0;
        for (int k = 0; k < fbs_pkg::ZONES; k++) begin
            n_zsum[k] = r_zsum[k];
        end
        for (int b = 0; b < fbs_pkg::WORD_BYTES; b++) begin
            w_smp          = w_word[fbs_pkg::BYTE_W*b +: fbs_pkg::BYTE_W];
            n_ssum         = n_ssum + fbs_pkg::SUM_W'(w_smp);
            n_zsum[n_zone] = n_zsum[n_zone] + fbs_pkg::SUM_W'(w_smp);
            if (w_smp < n_min) begin
                n_min = w_smp;
            end
            if (w_smp > n_max) begin
                n_max = w_smp;
            end
            if (n_zone != fbs_pkg::LAST_ZONE) begin
                if (n_zfill == LAST_FILL) begin
                    n_zone  = n_zone + 2'd1;
                    n_zfill = '0;
                end else begin
                    n_zfill = n_zfill + ZFILL_W'(1);
                end
            end
        end
    end

    always_comb begin
        n_totals.first_word     = n_first;
        n_totals.second_word    = n_second;
        n_totals.final_word     = w_word;
        n_totals.nonzero_words  = n_nonzero;
        n_totals.changing_words = n_change;
        n_totals.word_sum       = n_wsum;
        n_totals.sample_acc     = n_ssum;
        n_totals.lowest_sample  = n_min;
        n_totals.highest_sample = n_max;
        for (int k = 0; k < fbs_pkg::ZONES; k++) begin
            n_totals.zone_acc[k] = n_zsum[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_clear) begin
            r_pos     <= '0;
            r_first   <= '0;
            r_second  <= '0;
            r_prev    <= '0;
            r_nonzero <= '0;
            r_change  <= '0;
            r_wsum    <= '0;
            r_ssum    <= '0;
            r_min     <= '1;
            r_max     <= '0;
            r_zone    <= '0;
            r_zfill   <= '0;
            for (int k = 0; k < fbs_pkg::ZONES; k++) begin
                r_zsum[k] <= '0;
            end
        end else if (w_accept) begin
            r_pos     <= n_pos;
            r_first   <= n_first;
            r_second  <= n_second;
            r_prev    <= w_word;
            r_nonzero <= n_nonzero;
            r_change  <= n_change;
            r_wsum    <= n_wsum;
            r_ssum    <= n_ssum;
            r_min     <= n_min;
            r_max     <= n_max;
            r_zone    <= n_zone;
            r_zfill   <= n_zfill;
            for (int k = 0; k < fbs_pkg::ZONES; k++) begin
                r_zsum[k] <= n_zsum[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept && w_last) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_last) begin
            r_totals <= n_totals;
        end
    end

    assign o_valid  = r_valid;
    assign o_totals = r_totals;

endmodule

// ===== design/fbs_divide.sv =====
// Divides the frame and zone sample sums by their fixed sample counts.
// Each division is a multiply by a reciprocal worked out at elaboration. Depends on fbs_pkg.
module fbs_divide #(
    parameter int unsigned FRAME_WORDS  = fbs_pkg::FRAME_WORDS_DEF,
    parameter int unsigned ZONE_SAMPLES = fbs_pkg::ZONE_SAMPLES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  fbs_pkg::t_frame_totals i_totals,
    output logic                   o_ready,
    output logic                   o_valid,
    output fbs_pkg::t_frame_means  o_means,
    input  logic                   i_ready
);

    // Rounded-up reciprocals give the exact quotient for every dividend below 2^SUM_W.
    localparam int unsigned AvgDiv  = fbs_pkg::WORD_BYTES * FRAME_WORDS;
    localparam int unsigned AVG_SH  = fbs_pkg::SUM_W + $clog2(AvgDiv);
    localparam longint unsigned AVG_RECIP = ((64'd1 << AVG_SH) + AvgDiv - 1) / AvgDiv;
    localparam logic [fbs_pkg::MULT_W-1:0] AVG_MULT = fbs_pkg::MULT_W'(AVG_RECIP);

    logic [fbs_pkg::PROD_W-1:0] w_avg_prod;
    fbs_pkg::t_byte             w_avg;
    fbs_pkg::t_byte             w_zmean [fbs_pkg::ZONES];
    logic                       r_valid;
    fbs_pkg::t_frame_means      r_means;

    assign w_avg_prod = fbs_pkg::PROD_W'(i_totals.sample_acc) * fbs_pkg::PROD_W'(AVG_MULT);
    assign w_avg      = fbs_pkg::BYTE_W'(w_avg_prod >> AVG_SH);

    for (genvar k = 0; k < fbs_pkg::ZONES; k++) begin : g_zone
        // An empty zone has a zero sum, so any divisor gives the required zero.
        localparam int unsigned ZoneCnt =
            fbs_pkg::zone_samples_of(k, FRAME_WORDS, ZONE_SAMPLES);
        localparam int unsigned ZoneDiv = (ZoneCnt == 0) ? 1 : ZoneCnt;
        localparam int unsigned Z_SH    = fbs_pkg::SUM_W + $clog2(ZoneDiv);
        localparam longint unsigned Z_RECIP = ((64'd1 << Z_SH) + ZoneDiv - 1) / ZoneDiv;
        localparam logic [fbs_pkg::MULT_W-1:0] Z_MULT = fbs_pkg::MULT_W'(Z_RECIP);

        logic [fbs_pkg::PROD_W-1:0] w_prod;

        assign w_prod     = fbs_pkg::PROD_W'(i_totals.zone_acc[k]) * fbs_pkg::PROD_W'(Z_MULT);
        assign w_zmean[k] = fbs_pkg::BYTE_W'(w_prod >> Z_SH);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_means.first_word     <= i_totals.first_word;
            r_means.second_word    <= i_totals.second_word;
            r_means.final_word     <= i_totals.final_word;
            r_means.nonzero_words  <= i_totals.nonzero_words;
            r_means.changing_words <= i_totals.changing_words;
            r_means.word_sum       <= i_totals.word_sum;
            r_means.average_sample <= w_avg;
            r_means.lowest_sample  <= i_totals.lowest_sample;
            r_means.highest_sample <= i_totals.highest_sample;
            for (int k = 0; k < fbs_pkg::ZONES; k++) begin
                r_means.zone_mean[k] <= w_zmean[k];
            end
        end
    end

    assign o_valid = r_valid;
    assign o_means = r_means;

endmodule

// ===== design/fbs_percent.sv =====
// Converts the frame and zone means to percent and holds the result register.
// Depends on fbs_pkg and the fbs_out_if channel.
module fbs_percent #(
    parameter int unsigned FRAME_WORDS = fbs_pkg::FRAME_WORDS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  fbs_pkg::t_frame_means i_means,
    output logic                  o_ready,
    fbs_out_if.source             o_result
);

    localparam logic [fbs_pkg::SAMPLES_W-1:0] SAMPLES =
        fbs_pkg::SAMPLES_W'(fbs_pkg::WORD_BYTES * FRAME_WORDS);

    logic                                      r_valid;
    fbs_pkg::t_result                          r_out, n_out;

    always_comb begin
        n_out.first_word         = i_means.first_word;
        n_out.second_word        = i_means.second_word;
        n_out.final_word         = i_means.final_word;
        n_out.nonzero_words      = i_means.nonzero_words;
        n_out.changing_words     = i_means.changing_words;
        n_out.word_sum           = i_means.word_sum;
        n_out.samples_seen       = SAMPLES;
        n_out.average_sample     = i_means.average_sample;
        n_out.lowest_sample      = i_means.lowest_sample;
        n_out.highest_sample     = i_means.highest_sample;
        n_out.brightness_percent = fbs_pkg::pct_of(i_means.average_sample);
        for (int k = 0; k < fbs_pkg::ZONES; k++) begin
            n_out.zone_percents[fbs_pkg::PCT_W*k +: fbs_pkg::PCT_W] =
                fbs_pkg::pct_of(i_means.zone_mean[k]);
        end
    end

    assign o_ready = !r_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid              = r_valid;
    assign o_result.first_word         = r_out.first_word;
    assign o_result.second_word        = r_out.second_word;
    assign o_result.final_word         = r_out.final_word;
    assign o_result.nonzero_words      = r_out.nonzero_words;
    assign o_result.changing_words     = r_out.changing_words;
    assign o_result.word_sum           = r_out.word_sum;
    assign o_result.samples_seen       = r_out.samples_seen;
    assign o_result.average_sample     = r_out.average_sample;
    assign o_result.lowest_sample      = r_out.lowest_sample;
    assign o_result.highest_sample     = r_out.highest_sample;
    assign o_result.brightness_percent = r_out.brightness_percent;
    assign o_result.zone_percents      = r_out.zone_percents;

endmodule

// ===== tb/fbs_checker.sv =====
// Checker for the frame brightness statistics block: watches both channels, predicts
// the per-frame statistics from the accepted capture words and compares every result.
// Depends on fbs_pkg and the fbs_in_if / fbs_out_if channel interfaces.
module fbs_checker #(
    parameter int unsigned FRAME_WORDS  = fbs_pkg::FRAME_WORDS_DEF,
    parameter int unsigned ZONE_SAMPLES = fbs_pkg::ZONE_SAMPLES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fbs_in_if           i_capture,
    fbs_out_if          i_result,
    output int unsigned o_mismatches,
    output int unsigned o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [fbs_pkg::WORD_W-1:0] t_word;

    // Running statistics of the frame being gathered.
    int unsigned    words_in_frame;
    t_word          frame_first;
    t_word          frame_second;
    t_word          prev_word;
    int unsigned    nonzero_count;
    int unsigned    change_count;
    t_word          word_total;
    int unsigned    sample_total;
    int unsigned    samples_taken;
    fbs_pkg::t_byte min_sample;
    fbs_pkg::t_byte max_sample;
    int unsigned    zone_total [fbs_pkg::ZONES];
    int unsigned    zone_tally [fbs_pkg::ZONES];

    fbs_pkg::t_result expected_frame_stats[$];
    int unsigned      mismatch_total = 0;

    function automatic void clear_frame_stats();
        words_in_frame = 0;
        frame_first    = '0;
        frame_second   = '0;
        prev_word      = '0;
        nonzero_count  = 0;
        change_count   = 0;
        word_total     = '0;
        sample_total   = 0;
        samples_taken  = 0;
        min_sample     = 8'hFF;
        max_sample     = 8'h00;
        for (int k = 0; k < fbs_pkg::ZONES; k++) begin
            zone_total[k] = 0;
            zone_tally[k] = 0;
        end
    endfunction

    function automatic int unsigned brightness_of(input int unsigned mean);
        return (mean * 100) / 255;
    endfunction

    // Folds one captured word into the frame; on the closing word the frame's
    // statistics become the next expected result.
    function automatic void accumulate_word(input t_word w);
        fbs_pkg::t_byte   s;
        int unsigned      z;
        int unsigned      k;
        int unsigned      avg;
        int unsigned      zone_pct;
        logic [27:0]      zone_bits;
        fbs_pkg::t_result r;
        if (words_in_frame == 0) begin
            frame_first = w;
        end else begin
            if (words_in_frame == 1) begin
                frame_second = w;
            end
            if (w != prev_word) begin
                change_count++;
            end
        end
        if (w != '0) begin
            nonzero_count++;
        end
        word_total = word_total + w;
        prev_word  = w;
        for (k = 0; k < fbs_pkg::WORD_BYTES; k++) begin
            s = w[8*k +: 8];
            z = samples_taken / ZONE_SAMPLES;
            if (z > fbs_pkg::ZONES - 1) begin
                z = fbs_pkg::ZONES - 1;
            end
            sample_total += s;
            zone_total[z] += s;
            zone_tally[z]++;
            samples_taken++;
            if (s < min_sample) begin
                min_sample = s;
            end
            if (s > max_sample) begin
                max_sample = s;
            end
        end
        words_in_frame++;
        if (words_in_frame == FRAME_WORDS) begin
            avg       = sample_total / samples_taken;
            zone_bits = '0;
            for (k = 0; k < fbs_pkg::ZONES; k++) begin
                zone_pct = 0;
                if (zone_tally[k] > 0) begin
                    zone_pct = brightness_of(zone_total[k] / zone_tally[k]);
                end
                zone_bits[7*k +: 7] = 7'(zone_pct);
            end
            r.first_word         = frame_first;
            r.second_word        = frame_second;
            r.final_word         = w;
            r.nonzero_words      = 5'(nonzero_count);
            r.changing_words     = 4'(change_count);
            r.word_sum           = word_total;
            r.samples_seen       = 7'(samples_taken);
            r.average_sample     = 8'(avg);
            r.lowest_sample      = min_sample;
            r.highest_sample     = max_sample;
            r.brightness_percent = 7'(brightness_of(avg));
            r.zone_percents      = zone_bits;
            expected_frame_stats.push_back(r);
            clear_frame_stats();
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_total++;
        end
    endfunction

    function automatic void compare_result();
        fbs_pkg::t_result want;
        if (expected_frame_stats.size() == 0) begin
            $error("result transfer with no frame outstanding");
            mismatch_total++;
        end else begin
            want = expected_frame_stats.pop_front();
            check_field("first_word", want.first_word, i_result.first_word);
            check_field("second_word", want.second_word, i_result.second_word);
            check_field("final_word", want.final_word, i_result.final_word);
            check_field("nonzero_words", 32'(want.nonzero_words),
                        32'(i_result.nonzero_words));
            check_field("changing_words", 32'(want.changing_words),
                        32'(i_result.changing_words));
            check_field("word_sum", want.word_sum, i_result.word_sum);
            check_field("samples_seen", 32'(want.samples_seen), 32'(i_result.samples_seen));
            check_field("average_sample", 32'(want.average_sample),
                        32'(i_result.average_sample));
            check_field("lowest_sample", 32'(want.lowest_sample),
                        32'(i_result.lowest_sample));
            check_field("highest_sample", 32'(want.highest_sample),
                        32'(i_result.highest_sample));
            check_field("brightness_percent", 32'(want.brightness_percent),
                        32'(i_result.brightness_percent));
            check_field("zone_percents", 32'(want.zone_percents),
                        32'(i_result.zone_percents));
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_frame_stats();
            expected_frame_stats.delete();
        end else begin
            if (i_capture.valid && i_capture.ready) begin
                accumulate_word(i_capture.capture_word);
            end
            if (i_result.valid && i_result.ready) begin
                compare_result();
            end
        end
        o_outstanding <= expected_frame_stats.size();
        o_mismatches  <= mismatch_total;
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for frame_brightness_statistics_core: clock, reset, capture stimulus,
// result back-pressure, watchdog and verdict. Prediction and comparison live in fbs_checker.
// Depends on fbs_pkg, the channel interfaces, the block and fbs_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WATCHDOG_LIMIT    = 2000;
    localparam int unsigned RECV_HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES      = 10;
    localparam int unsigned FRAMES_PER_PHASE  = 16;
    localparam int unsigned FRAME_WORDS       = fbs_pkg::FRAME_WORDS_DEF;

    typedef enum int unsigned {
        FRAME_RANDOM,
        FRAME_ZONED,
        FRAME_REPEATS,
        FRAME_CONST,
        FRAME_ZERO,
        FRAME_FULL
    } t_frame_kind;

    logic i_clk;
    logic i_rst_n;

    fbs_in_if  cap_ch ();
    fbs_out_if res_ch ();

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          hold_results;

    // Extremes, repeats and alternating patterns in one frame.
    logic [31:0] directed_words [16] = '{
        32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'h00FF_00FF, 32'h1234_5678, 32'h1234_5678, 32'h8000_0000,
        32'h7FFF_FFFF, 32'h0000_0000, 32'h0101_0101, 32'hFEFE_FEFE,
        32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 32'h0000_0001
    };

    frame_brightness_statistics_core dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_capture (cap_ch),
        .o_result  (res_ch)
    );

    fbs_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_capture     (cap_ch),
        .i_result      (res_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
    end
    always #4 i_clk = ~i_clk;

    task automatic send_word(input logic [31:0] w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            cap_ch.valid        <= 1'b0;
            cap_ch.capture_word <= $urandom();
            @(posedge i_clk);
        end
        cap_ch.valid        <= 1'b1;
        cap_ch.capture_word <= w;
        @(posedge i_clk);
        while (!cap_ch.ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_frame(input t_frame_kind kind);
        logic [31:0]    w;
        logic [31:0]    repeat_word;
        fbs_pkg::t_byte level [fbs_pkg::ZONES];
        int             sample;
        int unsigned    i;
        int unsigned    b;
        repeat_word = $urandom();
        w           = repeat_word;
        for (i = 0; i < fbs_pkg::ZONES; i++) begin
            level[i] = 8'($urandom_range(0, 255));
        end
        for (i = 0; i < FRAME_WORDS; i++) begin
            case (kind)
                FRAME_RANDOM: begin
                    w = $urandom();
                end
                FRAME_ZONED: begin
                    // Each zone sits near its own level so the zone percents differ.
                    for (b = 0; b < fbs_pkg::WORD_BYTES; b++) begin
                        sample = int'(level[(i / 4) % fbs_pkg::ZONES])
                                 + int'($urandom_range(0, 16)) - 8;
                        if (sample < 0) begin
                            sample = 0;
                        end else if (sample > 255) begin
                            sample = 255;
                        end
                        w[8*b +: 8] = 8'(sample);
                    end
                end
                FRAME_REPEATS: begin
                    case ($urandom_range(0, 3))
                        0: w = '0;
                        1: w = '1;
                        2: w = repeat_word;
                        default: w = w;
                    endcase
                end
                FRAME_CONST: begin
                    w = repeat_word;
                end
                FRAME_ZERO: begin
                    w = '0;
                end
                default: begin
                    w = '1;
                end
            endcase
            send_word(w);
        end
    endtask

    task automatic send_random_frames(input int unsigned count);
        int unsigned n;
        t_frame_kind kind;
        for (n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: kind = FRAME_RANDOM;
                4, 5:       kind = FRAME_ZONED;
                6:          kind = FRAME_REPEATS;
                7:          kind = FRAME_CONST;
                8:          kind = FRAME_ZERO;
                default:    kind = FRAME_FULL;
            endcase
            send_frame(kind);
        end
    endtask

    // Stops offering words until every outstanding result has been transferred.
    task automatic wait_results_drained();
        cap_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_results && !hold_done) begin
                hold_done = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (RECV_HOLD_CYCLES) @(posedge i_clk);
            end else begin
                res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((cap_ch.valid && cap_ch.ready) || (res_ch.valid && res_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int unsigned i;
        send_idle_pct        = 29;
        recv_idle_pct        = 73;
        hold_results         = 1'b0;
        i_rst_n             <= 1'b0;
        cap_ch.valid        <= 1'b0;
        cap_ch.capture_word <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < FRAME_WORDS; i++) begin
            send_word(directed_words[i]);
        end
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        send_random_frames(FRAMES_PER_PHASE);

        send_idle_pct = 73;
        recv_idle_pct = 29;
        send_random_frames(FRAMES_PER_PHASE);

        // No idling; the result side holds off long enough for the pipeline to fill
        // and the closing word of a frame to be refused.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_results  = 1'b1;
        send_random_frames(FRAMES_PER_PHASE - 1);

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
